[rtl/crc32nc_pkg.sv]
package crc32nc_pkg;

  localparam int unsigned CrcW  = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CrcW-1:0] PolyReset = 32'hEDB8_8320;
  localparam logic [CrcW-1:0] SeedReset = 32'hFFFF_FFFF;
  localparam logic            FoldReset = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POLYNOMIAL = 2'd0,
    CFG_FOLD_NAMES = 2'd1,
    CFG_SEED_VALUE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CrcW-1:0] polynomial;
    logic            fold_names;
    logic [CrcW-1:0] seed_value;
  } cfg_t;

  localparam logic [ByteW-1:0] ChUpperA   = 8'h41;
  localparam logic [ByteW-1:0] ChUpperZ   = 8'h5A;
  localparam logic [ByteW-1:0] ChSlash    = 8'h2F;
  localparam logic [ByteW-1:0] ChBslash   = 8'h5C;
  localparam logic [ByteW-1:0] CaseOffset = 8'h20;

  function automatic logic [ByteW-1:0] fold_byte(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    r = b;
    if (b >= ChUpperA && b <= ChUpperZ) begin
      r = b + CaseOffset;
    end
    if (b == ChSlash) begin
      r = ChBslash;
    end
    return r;
  endfunction

  function automatic logic [CrcW-1:0] table_entry(input logic [ByteW-1:0] idx,
                                                  input logic [CrcW-1:0]  poly);
    logic [CrcW-1:0] c;
    c = {{(CrcW-ByteW){1'b0}}, idx};
    for (int k = 0; k < ByteW; k++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/crc32nc_if.sv]
interface crc32nc_in_if;
  import crc32nc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             first_byte;
  logic             last_byte;
  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface crc32nc_out_if;
  import crc32nc_pkg::*;
  logic            valid;
  logic            ready;
  logic [CrcW-1:0] crc;
  logic            done_res;
  modport source (output valid, crc, done_res, input ready);
  modport sink   (input valid, crc, done_res, output ready);
endinterface

[rtl/crc32nc_cfg.sv]
module crc32nc_cfg
  import crc32nc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CrcW-1:0]    cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.polynomial <= PolyReset;
      cfg_q.fold_names <= FoldReset;
      cfg_q.seed_value <= SeedReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POLYNOMIAL: cfg_q.polynomial <= cfg_data_i;
        CFG_FOLD_NAMES: cfg_q.fold_names <= cfg_data_i[0];
        CFG_SEED_VALUE: cfg_q.seed_value <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/crc32nc_update.sv]
module crc32nc_update
  import crc32nc_pkg::*;
(
  input  cfg_t             cfg_i,
  input  logic [CrcW-1:0]  crc_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             first_byte_i,
  output logic [CrcW-1:0]  crc_o
);

  logic [CrcW-1:0]  start;
  logic [ByteW-1:0] b;

  always_comb begin
    start = first_byte_i ? cfg_i.seed_value : crc_i;
    b     = cfg_i.fold_names ? fold_byte(data_byte_i) : data_byte_i;
    crc_o = table_entry(start[ByteW-1:0] ^ b, cfg_i.polynomial) ^ (start >> ByteW);
  end

endmodule

[rtl/crc32_name_checksum.sv]
// Reflected CRC-32 over a byte stream, no final inversion. One byte is taken per cycle
// unless the output stalls; each byte is held in the input register, and its running CRC
// goes into the CRC register through the single table step between the two; that register
// also holds the running value (all ones after reset). A byte with first_byte set starts
// from seed_value; fold_names maps A-Z to lower case and '/' to '\' before the update.
// Configuration writes take effect at once and belong in idle periods.
module crc32_name_checksum
  import crc32nc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CrcW-1:0]    cfg_data_i,
  crc32nc_in_if.sink         in_i,
  crc32nc_out_if.source      out_o
);

  cfg_t             cfg;
  logic             in_v_q;
  logic [ByteW-1:0] byte_q;
  logic             first_q;
  logic             last_q;
  logic             out_v_q;
  logic [CrcW-1:0]  crc_q;
  logic [CrcW-1:0]  crc_d;
  logic             done_q;
  logic             adv;
  logic             in_acc;

  crc32nc_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg)
  );

  crc32nc_update u_update (
    .cfg_i       (cfg),
    .crc_i       (crc_q),
    .data_byte_i (byte_q),
    .first_byte_i(first_q),
    .crc_o       (crc_d)
  );

  assign adv        = in_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !in_v_q || adv;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      crc_q   <= SeedReset;
    end else begin
      if (in_i.ready) begin
        in_v_q <= in_i.valid;
      end
      if (adv) begin
        out_v_q <= 1'b1;
        crc_q   <= crc_d;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q  <= in_i.data_byte;
      first_q <= in_i.first_byte;
      last_q  <= in_i.last_byte;
    end
    if (adv) begin
      done_q <= last_q;
    end
  end

  assign out_o.valid    = out_v_q;
  assign out_o.crc      = crc_q;
  assign out_o.done_res = done_q;

  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && !adv |=> in_v_q)
    else $error("input word dropped while stalled");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_v_q |-> in_i.ready)
    else $error("empty stage refused a word");

  a_crc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(crc_q))
    else $error("running crc changed without a word");

  a_adv_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_v_q)
    else $error("result lost after advance");

endmodule

[test/crc32_name_checksum_tb.sv]
`timescale 1ns / 1ps
module crc32_name_checksum_tb;
  import crc32nc_pkg::*;

  localparam int unsigned MaxGap     = 12;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [CrcW-1:0] crc;
    logic            done;
  } crc_word_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  cfg_idx_e        cfg_idx_i;
  logic [CrcW-1:0] cfg_data_i;

  crc32nc_in_if  byte_if ();
  crc32nc_out_if crc_if ();

  crc32_name_checksum i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (byte_if.sink),
    .out_o      (crc_if.source)
  );

  logic [CrcW-1:0] poly_q;
  logic [CrcW-1:0] seed_q;
  logic [CrcW-1:0] run_crc_q;
  logic            fold_q;
  crc_word_t       crc_exp_q[$];
  int unsigned     n_err       = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     rx_hold     = 0;
  bit              tx_idle     = 1'b1;
  bit              rx_idle     = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [ByteW-1:0] name_fold(input logic [ByteW-1:0] b);
    if (b >= ChUpperA && b <= ChUpperZ) begin
      return b | CaseOffset;
    end
    if (b == ChSlash) begin
      return ChBslash;
    end
    return b;
  endfunction

  // bitwise form of the reflected update, equal to the table step
  function automatic logic [CrcW-1:0] crc_advance(input logic [CrcW-1:0]  run,
                                                  input logic [ByteW-1:0] b,
                                                  input logic [CrcW-1:0]  poly);
    logic [CrcW-1:0] r;
    r = run ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int k = 0; k < ByteW; k++) begin
      r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [ByteW-1:0] name_char();
    case ($urandom_range(0, 5))
      0, 1: return ByteW'(ChUpperA + $urandom_range(0, 25));
      2: return ChSlash;
      3: return ByteW'(CaseOffset + ChUpperA + $urandom_range(0, 25));
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input logic first,
                           input logic last);
    int unsigned      gap;
    logic [ByteW-1:0] eff;
    crc_word_t        w;
    gap = tx_idle ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid      <= 1'b1;
    byte_if.data_byte  <= b;
    byte_if.first_byte <= first;
    byte_if.last_byte  <= last;
    do @(posedge clk_i); while (!byte_if.ready);
    eff       = fold_q ? name_fold(b) : b;
    run_crc_q = crc_advance(first ? seed_q : run_crc_q, eff, poly_q);
    w.crc     = run_crc_q;
    w.done    = last;
    crc_exp_q.push_back(w);
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(name_char(), i == 0, i == len - 1);
    end
  endtask

  task automatic drain();
    byte_if.valid <= 1'b0;
    while (crc_exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CrcW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_POLYNOMIAL: poly_q = val;
      CFG_FOLD_NAMES: fold_q = val[0];
      CFG_SEED_VALUE: seed_q = val;
      default: ;
    endcase
  endtask

  task automatic test_reset_values();
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(ChUpperA, 1'b1, 1'b0);
    send_byte(ChSlash, 1'b0, 1'b0);
    send_byte(ChUpperZ, 1'b0, 1'b0);
    send_byte(ChUpperA - 8'd1, 1'b0, 1'b0);
    send_byte(ChUpperZ + 8'd1, 1'b0, 1'b0);
    send_byte(ChBslash, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b1);
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b1);
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_POLYNOMIAL, '0);
    write_reg(CFG_FOLD_NAMES, '0);
    write_reg(CFG_SEED_VALUE, '0);
    send_byte(ChUpperA, 1'b1, 1'b0);
    send_byte(ChSlash, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    drain();
    // new polynomial applies from the next byte of the open message
    write_reg(CFG_POLYNOMIAL, '1);
    send_byte(8'hA5, 1'b0, 1'b1);
    drain();
    write_reg(CFG_POLYNOMIAL, PolyReset);
    write_reg(CFG_FOLD_NAMES, 32'd1);
    write_reg(CFG_SEED_VALUE, '1);
    send_byte(ChUpperZ, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_hold = HoldCycles;
    repeat (8) send_message($urandom_range(1, 8));
    drain();
  endtask

  task automatic test_random_messages();
    int unsigned     sent;
    int unsigned     len;
    logic [CrcW-1:0] val;
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 3))
        0: val = PolyReset;
        1: val = '0;
        2: val = '1;
        default: val = $urandom;
      endcase
      write_reg(CFG_POLYNOMIAL, val);
      write_reg(CFG_FOLD_NAMES, $urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: val = '0;
        1: val = '1;
        default: val = $urandom;
      endcase
      write_reg(CFG_SEED_VALUE, val);
      tx_idle = $urandom_range(0, 2) != 0;
      rx_idle = $urandom_range(0, 2) != 0;
      sent = 0;
      while (sent < 50) begin
        if ($urandom_range(0, 9) == 0) begin
          send_byte(ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
          sent++;
        end else begin
          len = $urandom_range(1, 10);
          send_message(len);
          sent += len;
        end
      end
      drain();
    end
  endtask

  initial begin : crc_sink
    int unsigned stall;
    crc_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_idle ? $urandom_range(0, MaxGap) : 0;
      end
      if (stall > 0) begin
        crc_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      crc_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(crc_if.valid && crc_if.ready));
    end
  end

  always @(posedge clk_i) begin : crc_check
    crc_word_t want;
    if (rst_ni && crc_if.valid && crc_if.ready) begin
      if (crc_exp_q.size() == 0) begin
        n_err++;
        if (n_err <= MaxReports) begin
          $display("crc word with none pending: crc %08h done %0b",
                   crc_if.crc, crc_if.done_res);
        end
      end else begin
        want = crc_exp_q.pop_front();
        if (crc_if.crc !== want.crc || crc_if.done_res !== want.done) begin
          n_err++;
          if (n_err <= MaxReports) begin
            $display("crc word: expected crc %08h done %0b, got crc %08h done %0b",
                     want.crc, want.done, crc_if.crc, crc_if.done_res);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (byte_if.valid && byte_if.ready) || (crc_if.valid && crc_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_POLYNOMIAL;
    cfg_data_i         <= '0;
    byte_if.valid      <= 1'b0;
    byte_if.data_byte  <= '0;
    byte_if.first_byte <= 1'b0;
    byte_if.last_byte  <= 1'b0;
    poly_q             = PolyReset;
    fold_q             = FoldReset;
    seed_q             = SeedReset;
    run_crc_q          = '1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_values();
    test_config_extremes();
    test_backpressure();
    test_random_messages();
    repeat (10) @(posedge clk_i);
    if (n_err == 0 && crc_exp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
